// File: src/cdt_pkg.sv
// Shared constants, command codes and control structs of the carrier drift tracker.
// No dependencies; the core, sequencer and datapath import this package.
`default_nettype none
package cdt_pkg;

  localparam int ALPHA_W   = 17;
  localparam int BW_W      = 31;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = 48;
  localparam int SHIFT_W   = 34;
  localparam int DIFF_W    = ACC_W + 1;
  localparam int MUL_LO_W  = 24;
  localparam int MUL_HI_W  = DIFF_W - MUL_LO_W;
  localparam int MUL_K_W   = WORD_W + 1;
  localparam int PROD_W    = MUL_HI_W + MUL_K_W;
  localparam int MAC_W     = DIFF_W + MUL_K_W;

  localparam int ALPHA_FRAC_BITS = 16;
  localparam int ACC_FRAC        = 12;
  localparam int INV_FRAC        = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_ALPHA     = 2'd0;
  localparam logic [1:0] CFG_BANDWIDTH = 2'd1;
  localparam logic [1:0] CFG_INV_FB    = 2'd2;
  localparam logic [1:0] CFG_GOAL      = 2'd3;

  // input item kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_LOCK   = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_CLEAR  = 4'd2;
  localparam logic [3:0] OP_LOCK   = 4'd3;
  localparam logic [3:0] OP_SKIP   = 4'd4;
  localparam logic [3:0] OP_RAW    = 4'd5;
  localparam logic [3:0] OP_D1     = 4'd6;
  localparam logic [3:0] OP_MLO    = 4'd7;
  localparam logic [3:0] OP_MHI    = 4'd8;
  localparam logic [3:0] OP_SH     = 4'd9;
  localparam logic [3:0] OP_D2     = 4'd10;
  localparam logic [3:0] OP_D3     = 4'd11;
  localparam logic [3:0] OP_COMMIT = 4'd12;
  localparam logic [3:0] OP_EMIT   = 4'd13;

  // multiplier coefficient select
  localparam logic K_ALPHA = 1'b0;
  localparam logic K_INV   = 1'b1;

  typedef struct packed {
    logic [3:0] op;
    logic       ksel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       locked;
    logic       stable;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: src/cdt_if.sv
// Valid/ready channel interfaces for PLL report items and tracker results.
// Field widths follow the fixed item formats; no package dependency.
`default_nettype none
interface cdt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] carrier;
  logic signed [31:0] channel;
  logic signed [31:0] lock_value;
  logic               last_in_batch;

  modport source (output valid, kind, carrier, channel, lock_value, last_in_batch,
                  input ready);
  modport sink   (input valid, kind, carrier, channel, lock_value, last_in_batch,
                  output ready);
endinterface

interface cdt_out_if;
  logic               valid;
  logic               ready;
  logic               event_res;
  logic [31:0]        sample_index;
  logic signed [31:0] carrier_out;
  logic signed [31:0] channel_out;
  logic signed [33:0] smooth_shift;
  logic signed [47:0] smooth_drift;
  logic               stable;
  logic               locked;
  logic               pll_reset;

  modport source (output valid, event_res, sample_index, carrier_out, channel_out,
                  smooth_shift, smooth_drift, stable, locked, pll_reset,
                  input ready);
  modport sink   (input valid, event_res, sample_index, carrier_out, channel_out,
                  smooth_shift, smooth_drift, stable, locked, pll_reset,
                  output ready);
endinterface
`default_nettype wire

// File: src/carrier_drift_tracker_core.sv
// Carrier drift tracker, top level: joins the sequencer and the datapath.
// Depends on cdt_pkg, cdt_if, cdt_ctrl and cdt_dp.
//
// Takes PLL report items (sample, lock, start) and returns at most one result
// per item through a registered output; a new item is taken while a result
// still waits. Start and ignored items give no result. For smoothed samples
// the shift filter, drift target and drift filter each pass twice through one
// shared 25 x 33 bit multiplier. The user must write configuration only
// while idle; the block itself does not enforce it.
`default_nettype none
module carrier_drift_tracker_core
  import cdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  cdt_in_if.sink                 in_chan,
  cdt_out_if.source              out_chan
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  logic              o_valid, o_event, o_stable, o_locked, o_preset;
  logic [WORD_W-1:0] o_index, o_carrier, o_channel;
  logic [SHIFT_W-1:0] o_shift;
  logic [ACC_W-1:0]  o_drift;

  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_chan.kind),
    .in_carrier    (in_chan.carrier),
    .in_channel    (in_chan.channel),
    .in_lock_value (in_chan.lock_value),
    .in_last       (in_chan.last_in_batch),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_chan.ready),
    .out_valid     (o_valid),
    .out_event     (o_event),
    .out_index     (o_index),
    .out_carrier   (o_carrier),
    .out_channel   (o_channel),
    .out_shift     (o_shift),
    .out_drift     (o_drift),
    .out_stable    (o_stable),
    .out_locked    (o_locked),
    .out_preset    (o_preset)
  );

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = o_valid;
  assign out_chan.event_res    = o_event;
  assign out_chan.sample_index = o_index;
  assign out_chan.carrier_out  = o_carrier;
  assign out_chan.channel_out  = o_channel;
  assign out_chan.smooth_shift = o_shift;
  assign out_chan.smooth_drift = o_drift;
  assign out_chan.stable       = o_stable;
  assign out_chan.locked       = o_locked;
  assign out_chan.pll_reset    = o_preset;

endmodule
`default_nettype wire

// File: src/cdt_ctrl.sv
// Sequencer of the carrier drift tracker: steps the datapath through one item.
// Depends on cdt_pkg for command codes and the command/status structs.
`default_nettype none
module cdt_ctrl
  import cdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_M1L    = 4'd2;
  localparam logic [3:0] S_M1H    = 4'd3;
  localparam logic [3:0] S_SH     = 4'd4;
  localparam logic [3:0] S_D2     = 4'd5;
  localparam logic [3:0] S_M2L    = 4'd6;
  localparam logic [3:0] S_M2H    = 4'd7;
  localparam logic [3:0] S_D3     = 4'd8;
  localparam logic [3:0] S_M3L    = 4'd9;
  localparam logic [3:0] S_M3H    = 4'd10;
  localparam logic [3:0] S_COMMIT = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.ksel  = K_ALPHA;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (stat.kind)
          KIND_START: begin
            cmd.op    = OP_CLEAR;
            state_nxt = S_IDLE;
          end
          KIND_LOCK: begin
            cmd.op    = OP_LOCK;
            state_nxt = S_EMIT;
          end
          KIND_SAMPLE: begin
            if (!stat.locked) begin
              cmd.op    = OP_SKIP;
              state_nxt = S_IDLE;
            end else if (!stat.stable) begin
              cmd.op    = OP_RAW;
              state_nxt = S_EMIT;
            end else begin
              cmd.op    = OP_D1;
              state_nxt = S_M1L;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_M1L: begin
        cmd.op    = OP_MLO;
        state_nxt = S_M1H;
      end
      S_M1H: begin
        cmd.op    = OP_MHI;
        state_nxt = S_SH;
      end
      S_SH: begin
        cmd.op    = OP_SH;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.op    = OP_D2;
        state_nxt = S_M2L;
      end
      S_M2L: begin
        cmd.op    = OP_MLO;
        cmd.ksel  = K_INV;
        state_nxt = S_M2H;
      end
      S_M2H: begin
        cmd.op    = OP_MHI;
        cmd.ksel  = K_INV;
        state_nxt = S_D3;
      end
      S_D3: begin
        cmd.op    = OP_D3;
        state_nxt = S_M3L;
      end
      S_M3L: begin
        cmd.op    = OP_MLO;
        state_nxt = S_M3H;
      end
      S_M3H: begin
        cmd.op    = OP_MHI;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted item did not move to evaluation");
`endif

endmodule
`default_nettype wire

// File: src/cdt_dp.sv
// Datapath of the carrier drift tracker: configuration, tracking state, shared
// two-pass multiplier and the result register. Depends on cdt_pkg.
`default_nettype none
module cdt_dp
  import cdt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [WORD_W-1:0]  cfg_data,
  input  wire logic [1:0]         in_kind,
  input  wire logic [WORD_W-1:0]  in_carrier,
  input  wire logic [WORD_W-1:0]  in_channel,
  input  wire logic [WORD_W-1:0]  in_lock_value,
  input  wire logic               in_last,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_event,
  output logic [WORD_W-1:0]       out_index,
  output logic [WORD_W-1:0]       out_carrier,
  output logic [WORD_W-1:0]       out_channel,
  output logic [SHIFT_W-1:0]      out_shift,
  output logic [ACC_W-1:0]        out_drift,
  output logic                    out_stable,
  output logic                    out_locked,
  output logic                    out_preset
);

  localparam logic [WORD_W-1:0] COUNT_MAX = '1;
  localparam logic [ACC_W-1:0]  MAX48     = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  MIN48     = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration
  logic [ALPHA_W-1:0] alpha_r;
  logic [BW_W-1:0]    bw_r;
  logic [WORD_W-1:0]  inv_fb_r;
  logic [WORD_W-1:0]  goal_r;

  // tracking state
  logic              lock_r, stable_r, alias_r;
  logic [WORD_W-1:0] count_r;
  logic [ACC_W-1:0]  shift_acc_r, drift_acc_r;

  // item and work registers
  logic [1:0]        kind_r;
  logic [WORD_W-1:0] carrier_r, channel_r;
  logic              lock_pos_r, last_r;
  logic [DIFF_W-1:0] d_r;
  logic [MAC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  sh_new_r;
  logic [WORD_W-1:0] idx_r;
  logic              preset_r, ev_r;

  // result register
  logic              out_valid_r, out_event_r, out_stable_r, out_locked_r, out_preset_r;
  logic [WORD_W-1:0] out_index_r, out_carrier_r, out_channel_r;
  logic [SHIFT_W-1:0] out_shift_r;
  logic [ACC_W-1:0]  out_drift_r;

  // combinational helpers
  logic [ALPHA_W-1:0]       a_eff;
  logic [WORD_W:0]          x, mag;
  logic                     preset_now, alias_nxt;
  logic [WORD_W-1:0]        count_inc;
  logic                     stable_hit;
  logic [MUL_HI_W-1:0]      mul_a;
  logic [WORD_W-1:0]        k_sel;
  logic signed [PROD_W-1:0] prod;
  logic [MAC_W-1:0]         prod_ext;
  logic [MAC_W-1:0]         acc_sh_a, acc_sh_i;
  logic [ACC_W+5:0]         v_full;
  logic [ACC_W-1:0]         v_sat;
  logic [ACC_W+1:0]         drift_sum;
  logic [ACC_W-1:0]         drift_new;
  logic                     out_free;

  assign a_eff = alpha_r[ALPHA_W-1] ? ALPHA_ONE : alpha_r;

  assign x   = {carrier_r[WORD_W-1], carrier_r} + {channel_r[WORD_W-1], channel_r};
  assign mag = carrier_r[WORD_W-1] ? ((WORD_W+1)'(0) - {1'b1, carrier_r})
                                   : {1'b0, carrier_r};

  // first alias of a batch raises the PLL reset request
  assign preset_now = !alias_r && (mag > {2'b00, bw_r});
  assign alias_nxt  = last_r ? 1'b0 : (alias_r | preset_now);

  assign count_inc  = (count_r == COUNT_MAX) ? count_r : count_r + WORD_W'(1);
  assign stable_hit = (count_inc >= goal_r);

  // shared multiplier: low part of d unsigned, high part signed
  assign mul_a = (cmd.op == OP_MHI) ? d_r[DIFF_W-1:MUL_LO_W]
                                    : {1'b0, d_r[MUL_LO_W-1:0]};
  assign k_sel = (cmd.ksel == K_INV) ? inv_fb_r : WORD_W'(a_eff);
  assign prod  = $signed(mul_a) * $signed({1'b0, k_sel});
  assign prod_ext = {{(MAC_W-PROD_W){prod[PROD_W-1]}}, prod};

  assign acc_sh_a = MAC_W'($signed(acc_r) >>> ALPHA_FRAC_BITS);
  assign acc_sh_i = MAC_W'($signed(acc_r) >>> (INV_FRAC + ACC_FRAC));

  assign v_full = acc_sh_i[ACC_W+5:0];
  always_comb begin
    if (v_full[ACC_W+5:ACC_W-1] == '0 || v_full[ACC_W+5:ACC_W-1] == '1) begin
      v_sat = v_full[ACC_W-1:0];
    end else if (v_full[ACC_W+5]) begin
      v_sat = MIN48;
    end else begin
      v_sat = MAX48;
    end
  end

  assign drift_sum = {{2{drift_acc_r[ACC_W-1]}}, drift_acc_r} + acc_sh_a[ACC_W+1:0];
  always_comb begin
    if (drift_sum[ACC_W+1:ACC_W-1] == '0 || drift_sum[ACC_W+1:ACC_W-1] == '1) begin
      drift_new = drift_sum[ACC_W-1:0];
    end else if (drift_sum[ACC_W+1]) begin
      drift_new = MIN48;
    end else begin
      drift_new = MAX48;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign stat.kind     = kind_r;
  assign stat.locked   = lock_r;
  assign stat.stable   = stable_r;
  assign stat.out_free = out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_W'(655);
      bw_r     <= '1;
      inv_fb_r <= WORD_W'(65536);
      goal_r   <= WORD_W'(30);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:     alpha_r  <= cfg_data[ALPHA_W-1:0];
        CFG_BANDWIDTH: bw_r     <= cfg_data[BW_W-1:0];
        CFG_INV_FB:    inv_fb_r <= cfg_data;
        CFG_GOAL:      goal_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r      <= 1'b0;
      stable_r    <= 1'b0;
      alias_r     <= 1'b0;
      count_r     <= '0;
      shift_acc_r <= '0;
      drift_acc_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          lock_r      <= 1'b0;
          stable_r    <= 1'b0;
          alias_r     <= 1'b0;
          count_r     <= '0;
          shift_acc_r <= '0;
          drift_acc_r <= '0;
        end
        OP_LOCK: begin
          lock_r <= lock_pos_r;
          if (!lock_pos_r) begin
            count_r  <= '0;
            stable_r <= 1'b0;
          end
        end
        OP_SKIP: begin
          if (last_r) alias_r <= 1'b0;
        end
        OP_RAW: begin
          shift_acc_r <= {{(ACC_W-WORD_W-1-ACC_FRAC){x[WORD_W]}}, x, ACC_FRAC'(0)};
          alias_r     <= alias_nxt;
          count_r     <= count_inc;
          stable_r    <= stable_hit;
        end
        OP_COMMIT: begin
          shift_acc_r <= sh_new_r;
          drift_acc_r <= drift_new;
          alias_r     <= alias_nxt;
          count_r     <= count_inc;
        end
        default: ;
      endcase
    end
  end

  // item capture and arithmetic work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r     <= in_kind;
        carrier_r  <= in_carrier;
        channel_r  <= in_channel;
        lock_pos_r <= !in_lock_value[WORD_W-1] && (in_lock_value != '0);
        last_r     <= in_last;
      end
      OP_LOCK: ev_r <= 1'b1;
      OP_RAW: begin
        ev_r     <= 1'b0;
        idx_r    <= count_r;
        preset_r <= preset_now;
      end
      OP_D1: begin
        d_r <= {{(DIFF_W-WORD_W-1-ACC_FRAC){x[WORD_W]}}, x, ACC_FRAC'(0)}
               - {shift_acc_r[ACC_W-1], shift_acc_r};
      end
      OP_MLO: acc_r <= prod_ext;
      OP_MHI: acc_r <= acc_r + (prod_ext << MUL_LO_W);
      OP_SH:  sh_new_r <= shift_acc_r + acc_sh_a[ACC_W-1:0];
      OP_D2: begin
        d_r <= {sh_new_r[ACC_W-1], sh_new_r} - {shift_acc_r[ACC_W-1], shift_acc_r};
      end
      OP_D3: d_r <= {v_sat[ACC_W-1], v_sat} - {drift_acc_r[ACC_W-1], drift_acc_r};
      OP_COMMIT: begin
        ev_r     <= 1'b0;
        idx_r    <= count_r;
        preset_r <= preset_now;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_event_r   <= ev_r;
      out_index_r   <= ev_r ? count_r : idx_r;
      out_carrier_r <= ev_r ? '0 : carrier_r;
      out_channel_r <= ev_r ? '0 : channel_r;
      out_shift_r   <= shift_acc_r[SHIFT_W+ACC_FRAC-1:ACC_FRAC];
      out_drift_r   <= drift_acc_r;
      out_stable_r  <= stable_r;
      out_locked_r  <= lock_r;
      out_preset_r  <= ev_r ? 1'b0 : preset_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_event   = out_event_r;
  assign out_index   = out_index_r;
  assign out_carrier = out_carrier_r;
  assign out_channel = out_channel_r;
  assign out_shift   = out_shift_r;
  assign out_drift   = out_drift_r;
  assign out_stable  = out_stable_r;
  assign out_locked  = out_locked_r;
  assign out_preset  = out_preset_r;

`ifndef SYNTHESIS
  a_stable_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> lock_r)
    else $error("stable flag set while unlocked");
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> out_free)
    else $error("result loaded over a pending transfer");
  a_shift_update_op: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_RAW && cmd.op != OP_COMMIT && cmd.op != OP_CLEAR)
      |=> $stable(shift_acc_r))
    else $error("smoothed shift changed outside a commit");
`endif

endmodule
`default_nettype wire
